// File: sv/psb_pkg.sv
// psb_pkg: beat types and fixed constants for polygon_screen_bounds.
// No dependencies; imported by the top level.
package psb_pkg;

    localparam int COORD_W   = 32;
    localparam int CLIP_W    = 48;
    localparam int BOX_W     = 16;
    localparam int COEF_W    = 64;
    localparam int NUM_COEF  = 8;
    localparam int CFG_IDX_W = 4;
    localparam int ACC_W     = 98;
    localparam int MAG_W     = 64;
    localparam int DIV_W     = 53;
    localparam int Q_BITS    = 14;
    localparam int EPS       = 7;
    localparam int MIN_POLY  = 3;

    localparam logic signed [BOX_W-1:0] Q14_ONE = 16'sd16384;

    typedef struct packed {
        logic signed [COORD_W-1:0] vertex_x;
        logic signed [COORD_W-1:0] vertex_y;
        logic signed [COORD_W-1:0] vertex_z;
        logic                      last_vertex;
    } t_vertex;

    typedef struct packed {
        logic signed [BOX_W-1:0] box_min_x;
        logic signed [BOX_W-1:0] box_min_y;
        logic signed [BOX_W-1:0] box_max_x;
        logic signed [BOX_W-1:0] box_max_y;
        logic                    box_empty;
    } t_result;

endpackage

// File: sv/polygon_screen_bounds.sv
// polygon_screen_bounds: transform, near-plane crossing and screen box of a polygon.
// Depends on psb_pkg (beat types and constants).
//
// One vertex beat is taken when start is high and busy is low; busy then stays high
// until the vertex is done. A vertex runs the transform (nine products on the one
// 32x32 multiplier), then for each edge that crosses the near plane eight partial
// products and a 14-step divide per coordinate, and when the vertex lies in front
// of the plane two 14-step divides; the last vertex may add its closing edge. The
// multiplier is shared and the divider gives one quotient bit a cycle. On the last
// vertex the box is shown for exactly one cycle with o_result_strobe; the receiver
// cannot stall it. Write the matrix registers only while busy is low.
module polygon_screen_bounds #(
    parameter int MAX_VERTICES = 255
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      start,
    output logic                                      busy,
    input  psb_pkg::t_vertex                          i_vertex,
    input  logic                                      i_cfg_we,
    input  logic [psb_pkg::CFG_IDX_W-1:0]             i_cfg_index,
    input  logic [psb_pkg::COEF_W-1:0]                i_cfg_data,
    output psb_pkg::t_result                          o_result,
    output logic                                      o_result_strobe
);
    import psb_pkg::*;

    localparam int CNT_W = $clog2(MAX_VERTICES + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
    localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(MIN_POLY);
    localparam logic signed [ACC_W-1:0] ACC_CLIP_MAX = (ACC_W'(1) << (CLIP_W - 1)) - 1;
    localparam logic signed [ACC_W-1:0] ACC_CLIP_MIN = -(ACC_W'(1) << (CLIP_W - 1));
    localparam logic signed [CLIP_W-1:0] CLIP_EPS = CLIP_W'(EPS);
    localparam int TK_EDGE  = 0;
    localparam int TK_VERT  = 1;
    localparam int TK_CLOSE = 2;

    typedef enum logic [13:0] {
        S_IDLE       = 14'b00000000000001,
        S_CLIP       = 14'b00000000000010,
        S_CLIP_DRAIN = 14'b00000000000100,
        S_DECIDE     = 14'b00000000001000,
        S_NEXT       = 14'b00000000010000,
        S_EDGE_SETUP = 14'b00000000100000,
        S_EDGE_MUL   = 14'b00000001000000,
        S_EDGE_DRAIN = 14'b00000010000000,
        S_EDGE_NORM  = 14'b00000100000000,
        S_VERT       = 14'b00001000000000,
        S_DIV_START  = 14'b00010000000000,
        S_DIV_RUN    = 14'b00100000000000,
        S_DIV_END    = 14'b01000000000000,
        S_ADD_POINT  = 14'b10000000000000
    } t_state;

    typedef enum logic [1:0] {
        TASK_EDGE  = 2'd0,
        TASK_VERT  = 2'd1,
        TASK_CLOSE = 2'd2
    } t_task;

    typedef struct packed {
        logic       valid;
        logic       clip;
        logic       neg;
        logic       first;
        logic       last;
        logic [1:0] shift;
        logic [1:0] col;
    } t_tag;

    t_state r_state, n_state;

    logic [COEF_W-1:0]         r_coef [NUM_COEF];
    logic signed [COORD_W-1:0] r_p [3];
    logic                      r_last;
    logic signed [CLIP_W-1:0]  r_cur [3];
    logic signed [CLIP_W-1:0]  r_prior [3];
    logic signed [CLIP_W-1:0]  r_first [3];
    logic                      r_cur_in, r_prior_in, r_first_in;
    logic signed [BOX_W-1:0]   r_box [4];
    logic                      r_bvalid;
    logic [CNT_W-1:0]          r_vcount;
    logic signed [BOX_W-1:0]   r_pt [2];

    logic [2:0]                r_todo;
    t_task                     r_task;
    logic                      r_k;
    logic [1:0]                r_col, r_row;
    logic [2:0]                r_step;

    logic [2*COORD_W-1:0]      r_prod;
    t_tag                      r_tag, n_tag;
    logic signed [ACC_W-1:0]   r_acc;

    logic [CLIP_W-1:0]         r_amag, r_bmag;
    logic                      r_aneg, r_bneg;

    logic                      r_dneg, r_dover, r_dsat;
    logic [MAG_W-1:0]          r_dmag;
    logic [DIV_W-1:0]          r_dd, r_rem;
    logic [Q_BITS-1:0]         r_q;
    logic [3:0]                r_dcnt;

    t_result                   r_out;
    logic                      r_strobe;

    function automatic logic [CLIP_W-1:0] mag48(input logic signed [CLIP_W-1:0] v);
        mag48 = v[CLIP_W-1] ? CLIP_W'(-v) : CLIP_W'(v);
    endfunction

    function automatic logic [COORD_W-1:0] mag32(input logic signed [COORD_W-1:0] v);
        mag32 = v[COORD_W-1] ? COORD_W'(-v) : COORD_W'(v);
    endfunction

    function automatic logic signed [COORD_W-1:0] coef_entry(
        input logic [COEF_W-1:0] c_lo_row, input logic half);
        coef_entry = half ? c_lo_row[63:32] : c_lo_row[31:0];
    endfunction

    assign busy            = (r_state != S_IDLE);
    assign o_result        = r_out;
    assign o_result_strobe = r_strobe;

    // Edge operands: the closing edge runs from the current vertex back to the first.
    logic signed [CLIP_W-1:0] edge_p [3];
    logic signed [CLIP_W-1:0] edge_c [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_task == TASK_CLOSE) begin
                edge_p[i] = r_cur[i];
                edge_c[i] = r_first[i];
            end else begin
                edge_p[i] = r_prior[i];
                edge_c[i] = r_cur[i];
            end
        end
    end

    // Multiplier operand selection.
    logic [1:0]                mat_col;
    logic signed [COORD_W-1:0] clip_x, clip_c;
    logic signed [CLIP_W-1:0]  edge_x;
    logic [CLIP_W-1:0]         edge_xmag, edge_ymag;
    logic                      edge_yneg;
    logic [COORD_W-1:0]        mul_a, mul_b;
    always_comb begin
        mat_col   = (r_col == 2'd2) ? 2'd3 : r_col;
        clip_x    = r_p[r_row];
        clip_c    = coef_entry(r_coef[{r_row[0], r_row[1] ? 1'b1 : 1'b0, mat_col[1]} == 3'd0
                               ? 3'd0 : {r_row, mat_col[1]}], mat_col[0]);
        edge_x    = r_step[2] ? edge_c[{1'b0, r_k}] : edge_p[{1'b0, r_k}];
        edge_xmag = mag48(edge_x);
        edge_ymag = r_step[2] ? r_bmag : r_amag;
        edge_yneg = r_step[2] ? r_bneg : r_aneg;
        n_tag     = '0;
        if (r_state == S_CLIP) begin
            mul_a       = mag32(clip_x);
            mul_b       = mag32(clip_c);
            n_tag.valid = 1'b1;
            n_tag.clip  = 1'b1;
            n_tag.neg   = clip_x[COORD_W-1] ^ clip_c[COORD_W-1];
            n_tag.first = (r_row == 2'd0);
            n_tag.last  = (r_row == 2'd2);
            n_tag.col   = r_col;
        end else begin
            mul_a       = r_step[1] ? COORD_W'(edge_xmag[CLIP_W-1:COORD_W])
                                    : edge_xmag[COORD_W-1:0];
            mul_b       = r_step[0] ? COORD_W'(edge_ymag[CLIP_W-1:COORD_W])
                                    : edge_ymag[COORD_W-1:0];
            n_tag.valid = (r_state == S_EDGE_MUL);
            n_tag.neg   = edge_x[CLIP_W-1] ^ edge_yneg;
            n_tag.first = (r_step == 3'd0);
            n_tag.shift = 2'(r_step[1]) + 2'(r_step[0]);
        end
    end

    // Accumulate stage, fed by the registered multiplier product.
    logic [1:0]                acc_mcol;
    logic signed [COORD_W-1:0] trans_c;
    logic signed [2*COORD_W:0] prod_s;
    logic signed [ACC_W-1:0]   prod_ext, term, base, acc_next, acc_sat;
    always_comb begin
        acc_mcol = (r_tag.col == 2'd2) ? 2'd3 : r_tag.col;
        trans_c  = coef_entry(r_coef[{2'd3, acc_mcol[1]}], acc_mcol[0]);
        prod_s   = r_tag.neg ? -$signed({1'b0, r_prod}) : $signed({1'b0, r_prod});
        prod_ext = ACC_W'(prod_s);
        if (r_tag.clip) begin
            // floor each product to Q.16 before it is summed
            term = prod_ext >>> 16;
        end else begin
            term = prod_ext <<< {r_tag.shift, 5'b0};
        end
        if (r_tag.first) begin
            base = r_tag.clip ? ACC_W'(trans_c) : '0;
        end else begin
            base = r_acc;
        end
        acc_next = base + term;
        if (acc_next > ACC_CLIP_MAX) begin
            acc_sat = ACC_CLIP_MAX;
        end else if (acc_next < ACC_CLIP_MIN) begin
            acc_sat = ACC_CLIP_MIN;
        end else begin
            acc_sat = acc_next;
        end
    end

    // Edge setup values.
    logic signed [49:0] ea, eb, eden, ea_s, eb_s;
    logic [49:0]        den_u;
    always_comb begin
        ea    = 50'(edge_c[2]) - 50'(EPS);
        eb    = 50'(EPS) - 50'(edge_p[2]);
        eden  = ea + eb;
        ea_s  = eden[49] ? -ea : ea;
        eb_s  = eden[49] ? -eb : eb;
        den_u = eden[49] ? 50'(-eden) : 50'(eden);
    end

    // Normalize and divide helpers.
    logic                     norm_neg;
    logic [ACC_W-1:0]         norm_mag;
    logic                     cur_in_now, first_in_eff;
    logic [DIV_W-1:0]         rem2;
    logic                     rem_ge;
    logic signed [BOX_W-1:0]  div_res;
    logic [CNT_W-1:0]         vcount_next;
    logic                     out_empty;
    always_comb begin
        norm_neg     = r_acc[ACC_W-1];
        norm_mag     = norm_neg ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        cur_in_now   = (r_cur[2] > CLIP_EPS);
        first_in_eff = (r_vcount == '0) ? cur_in_now : r_first_in;
        rem2         = {r_rem[DIV_W-2:0], 1'b0};
        rem_ge       = (rem2 >= r_dd);
        if (r_dsat) begin
            div_res = r_dneg ? -Q14_ONE : Q14_ONE;
        end else if (r_dneg) begin
            div_res = -$signed(BOX_W'(r_q)) - BOX_W'(r_rem != '0);
        end else begin
            div_res = BOX_W'(r_q);
        end
        vcount_next  = (r_vcount == CNT_MAX) ? r_vcount : r_vcount + 1'b1;
        out_empty    = !r_bvalid || (vcount_next < CNT_MIN);
    end

    // Sequencer.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:       if (start) n_state = S_CLIP;
            S_CLIP:       if (r_col == 2'd2 && r_row == 2'd2) n_state = S_CLIP_DRAIN;
            S_CLIP_DRAIN: n_state = S_DECIDE;
            S_DECIDE:     n_state = S_NEXT;
            S_NEXT: begin
                if (r_todo[TK_EDGE] || r_todo[TK_CLOSE]) begin
                    n_state = r_todo[TK_EDGE] || !r_todo[TK_VERT] ? S_EDGE_SETUP : S_VERT;
                end else if (r_todo[TK_VERT]) begin
                    n_state = S_VERT;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_EDGE_SETUP: n_state = S_EDGE_MUL;
            S_EDGE_MUL:   if (r_step == 3'd7) n_state = S_EDGE_DRAIN;
            S_EDGE_DRAIN: n_state = S_EDGE_NORM;
            S_EDGE_NORM:  n_state = S_DIV_START;
            S_VERT:       n_state = S_DIV_START;
            S_DIV_START: begin
                if (r_dover || r_dd == '0 || r_dmag >= MAG_W'(r_dd)) begin
                    n_state = S_DIV_END;
                end else begin
                    n_state = S_DIV_RUN;
                end
            end
            S_DIV_RUN:    if (r_dcnt == 4'(Q_BITS - 1)) n_state = S_DIV_END;
            S_DIV_END: begin
                if (!r_k) begin
                    n_state = (r_task == TASK_VERT) ? S_VERT : S_EDGE_MUL;
                end else begin
                    n_state = S_ADD_POINT;
                end
            end
            S_ADD_POINT:  n_state = S_NEXT;
            default:      n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        // datapath, no reset needed
        r_prod <= mul_a * mul_b;
        if (r_tag.valid) begin
            r_acc <= acc_next;
            if (r_tag.clip && r_tag.last) begin
                r_cur[r_tag.col] <= CLIP_W'(acc_sat);
            end
        end
        if (r_state == S_IDLE && start) begin
            r_p[0] <= i_vertex.vertex_x;
            r_p[1] <= i_vertex.vertex_y;
            r_p[2] <= i_vertex.vertex_z;
            r_last <= i_vertex.last_vertex;
        end
        if (r_state == S_DECIDE && r_vcount == '0) begin
            r_first <= r_cur;
        end
        if (r_state == S_NEXT && r_todo == '0) begin
            r_prior <= r_cur;
        end
        if (r_state == S_EDGE_SETUP) begin
            r_amag <= CLIP_W'(ea_s[49] ? -ea_s : ea_s);
            r_aneg <= ea_s[49];
            r_bmag <= CLIP_W'(eb_s[49] ? -eb_s : eb_s);
            r_bneg <= eb_s[49];
            r_dd   <= (DIV_W'(den_u) << 3) - DIV_W'(den_u);
        end
        if (r_state == S_EDGE_NORM) begin
            r_dneg  <= norm_neg;
            r_dover <= (norm_mag[ACC_W-1:MAG_W] != '0);
            r_dmag  <= norm_mag[MAG_W-1:0];
        end
        if (r_state == S_VERT) begin
            r_dneg  <= r_cur[{1'b0, r_k}][CLIP_W-1];
            r_dover <= 1'b0;
            r_dmag  <= MAG_W'(mag48(r_cur[{1'b0, r_k}]));
            r_dd    <= DIV_W'(unsigned'(r_cur[2]));
        end
        if (r_state == S_DIV_START) begin
            r_dsat <= r_dover || r_dd == '0 || r_dmag >= MAG_W'(r_dd);
            r_rem  <= r_dmag[DIV_W-1:0];
            r_q    <= '0;
        end
        if (r_state == S_DIV_RUN) begin
            r_rem <= rem_ge ? rem2 - r_dd : rem2;
            r_q   <= {r_q[Q_BITS-2:0], rem_ge};
        end
        if (r_state == S_DIV_END) begin
            r_pt[r_k] <= div_res;
        end
        if (r_state == S_ADD_POINT) begin
            if (!r_bvalid) begin
                r_box[0] <= r_pt[0];
                r_box[1] <= r_pt[1];
                r_box[2] <= r_pt[0];
                r_box[3] <= r_pt[1];
            end else begin
                if (r_pt[0] < r_box[0]) r_box[0] <= r_pt[0];
                if (r_pt[1] < r_box[1]) r_box[1] <= r_pt[1];
                if (r_pt[0] > r_box[2]) r_box[2] <= r_pt[0];
                if (r_pt[1] > r_box[3]) r_box[3] <= r_pt[1];
            end
        end
        if (r_state == S_NEXT && r_todo == '0 && r_last) begin
            r_out.box_min_x <= out_empty ? '0 : r_box[0];
            r_out.box_min_y <= out_empty ? '0 : r_box[1];
            r_out.box_max_x <= out_empty ? '0 : r_box[2];
            r_out.box_max_y <= out_empty ? '0 : r_box[3];
            r_out.box_empty <= out_empty;
        end

        // control
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_tag      <= '0;
            r_strobe   <= 1'b0;
            r_cur_in   <= 1'b0;
            r_prior_in <= 1'b0;
            r_first_in <= 1'b0;
            r_bvalid   <= 1'b0;
            r_vcount   <= '0;
            r_todo     <= '0;
            r_task     <= TASK_EDGE;
            r_k        <= 1'b0;
            r_col      <= '0;
            r_row      <= '0;
            r_step     <= '0;
            r_dcnt     <= '0;
            for (int i = 0; i < NUM_COEF; i++) begin
                r_coef[i] <= '0;
            end
        end else begin
            r_state  <= n_state;
            r_tag    <= n_tag;
            r_strobe <= (r_state == S_NEXT) && (r_todo == '0) && r_last;
            if (i_cfg_we && i_cfg_index < CFG_IDX_W'(NUM_COEF)) begin
                r_coef[i_cfg_index[2:0]] <= i_cfg_data;
            end
            unique case (r_state)
                S_IDLE: begin
                    r_col <= '0;
                    r_row <= '0;
                end
                S_CLIP: begin
                    if (r_row == 2'd2) begin
                        r_row <= '0;
                        r_col <= r_col + 1'b1;
                    end else begin
                        r_row <= r_row + 1'b1;
                    end
                end
                S_DECIDE: begin
                    r_cur_in <= cur_in_now;
                    if (r_vcount == '0) r_first_in <= cur_in_now;
                    r_todo[TK_EDGE]  <= (r_vcount != '0) && (r_prior_in != cur_in_now);
                    r_todo[TK_VERT]  <= cur_in_now;
                    r_todo[TK_CLOSE] <= r_last && (first_in_eff != cur_in_now);
                end
                S_NEXT: begin
                    r_k <= 1'b0;
                    if (r_todo[TK_EDGE]) begin
                        r_task          <= TASK_EDGE;
                        r_todo[TK_EDGE] <= 1'b0;
                    end else if (r_todo[TK_VERT]) begin
                        r_task          <= TASK_VERT;
                        r_todo[TK_VERT] <= 1'b0;
                    end else if (r_todo[TK_CLOSE]) begin
                        r_task           <= TASK_CLOSE;
                        r_todo[TK_CLOSE] <= 1'b0;
                    end else begin
                        // vertex done: advance history, emit and drop the polygon on last
                        if (r_last) begin
                            r_vcount   <= '0;
                            r_bvalid   <= 1'b0;
                            r_prior_in <= 1'b0;
                            r_first_in <= 1'b0;
                        end else begin
                            r_prior_in <= r_cur_in;
                            r_vcount   <= vcount_next;
                        end
                    end
                end
                S_EDGE_SETUP: r_step <= '0;
                S_EDGE_MUL:   r_step <= r_step + 1'b1;
                S_DIV_START:  r_dcnt <= '0;
                S_DIV_RUN:    r_dcnt <= r_dcnt + 1'b1;
                S_DIV_END: begin
                    if (!r_k) begin
                        r_k    <= 1'b1;
                        r_step <= '0;
                    end
                end
                S_ADD_POINT:  r_bvalid <= 1'b1;
                default: ;
            endcase
        end
    end

endmodule
